@@ rtl/bmsi_pkg.sv @@
package bmsi_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] CMD_REG_WRITE   = 2'd0;
    localparam logic [1:0] CMD_PIC_UPDATE  = 2'd1;
    localparam logic [1:0] CMD_CPU_XLATE   = 2'd2;
    localparam logic [1:0] CMD_PIC_XLATE   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FOUR_SCREEN  = 2'd0;
    localparam logic [1:0] CFG_REVISION_B   = 2'd1;
    localparam logic [1:0] CFG_EDGE_MIN_GAP = 2'd2;

    // register groups selected by cpu address bits 14..13
    localparam logic [1:0] GRP_BANK   = 2'd0;
    localparam logic [1:0] GRP_MIRROR = 2'd1;
    localparam logic [1:0] GRP_LATCH  = 2'd2;
    localparam logic [1:0] GRP_ENABLE = 2'd3;

    localparam logic [7:0] EDGE_GAP_RESET   = 8'd16;
    localparam logic [7:0] PRG_FIXED_SECOND = 8'hfe;
    localparam logic [7:0] PRG_FIXED_LAST   = 8'hff;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int VALUE_W  = 8;
    localparam int CYCLE_W  = 32;
    localparam int BANK_W   = 8;
    localparam int PRG_W    = 6;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // bank state seen by the address translator
    typedef struct packed {
        logic                  swap_prg;
        logic                  swap_pic;
        logic [7:0][BANK_W-1:0] pic_banks;
        logic [1:0][PRG_W-1:0]  prog_banks;
    } t_bank_map;

endpackage

@@ rtl/bmsi_translate.sv @@
module bmsi_translate (
    input  logic [bmsi_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bmsi_pkg::ADDR_W-1:0] i_address,
    input  bmsi_pkg::t_bank_map         i_map,
    output logic [bmsi_pkg::BANK_W-1:0] o_bank
);

    logic [1:0] cpu_slot;
    logic [2:0] pic_slot;
    logic [bmsi_pkg::BANK_W-1:0] cpu_bank;
    logic [bmsi_pkg::BANK_W-1:0] pic_bank;

    always_comb begin
        // even program slots swap when the mode bit is set
        cpu_slot = i_address[14:13];
        if (!cpu_slot[0] && i_map.swap_prg) begin
            cpu_slot = cpu_slot ^ 2'b10;
        end
        case (cpu_slot)
            2'd0:    cpu_bank = {2'b00, i_map.prog_banks[0]};
            2'd1:    cpu_bank = {2'b00, i_map.prog_banks[1]};
            2'd2:    cpu_bank = bmsi_pkg::PRG_FIXED_SECOND;
            default: cpu_bank = bmsi_pkg::PRG_FIXED_LAST;
        endcase
        if (!i_address[15]) begin
            cpu_bank = '0;
        end

        pic_slot = i_address[12:10] ^ {i_map.swap_pic, 2'b00};
        pic_bank = i_map.pic_banks[pic_slot];
        if (i_address[15:13] != 3'd0) begin
            pic_bank = '0;
        end

        case (i_cmd)
            bmsi_pkg::CMD_CPU_XLATE: o_bank = cpu_bank;
            bmsi_pkg::CMD_PIC_XLATE: o_bank = pic_bank;
            default:                 o_bank = '0;
        endcase
    end

endmodule

@@ rtl/bank_mapper_scanline_irq_unit.sv @@
// Cartridge bank mapper with scanline interrupt counter. Each input transaction carries a
// register write, a picture address update with cycle stamp, or a cpu/picture address
// translation (kind on tuser) and gives exactly one output transaction with the bank
// number and the interrupt, work RAM and mirroring status after that item. An item passes
// through the input register, then the state update and result register, and one item is
// accepted every cycle while the output is not held by back-pressure.
module bank_mapper_scanline_irq_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // address[15:0], value[23:16], ppu_cycle[55:24]
    input  logic [1:0]  i_s_axis_tuser,  // cmd[1:0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // bank[7:0], irq_line[8], ram_read_ok[9],
                                         // ram_write_ok[10], horiz_mirror[11]
);

    // configuration
    logic r_four_screen;
    logic r_revision_b;
    logic [7:0] r_edge_min_gap;

    // input stage
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [15:0] r_in_address;
    logic [7:0]  r_in_value;
    logic [31:0] r_in_cycle;

    // output stage
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [15:0] n_out_data;

    // mapper state
    logic [7:0]      r_command;
    logic [7:0][7:0] r_pic_banks;
    logic [1:0][5:0] r_prog_banks;
    logic r_ram_enabled, r_ram_protected, r_mirror;
    logic [7:0] r_irq_latch, r_irq_count;
    logic r_irq_reload, r_irq_enable, r_irq_pending, r_prev_bit12;
    logic [31:0] r_last_edge;

    logic [7:0]      n_command;
    logic [7:0][7:0] n_pic_banks;
    logic [1:0][5:0] n_prog_banks;
    logic n_ram_enabled, n_ram_protected, n_mirror;
    logic [7:0] n_irq_latch, n_irq_count;
    logic n_irq_reload, n_irq_enable, n_irq_pending, n_prev_bit12;
    logic [31:0] n_last_edge;

    logic advance;
    logic [2:0] sel;
    logic [2:0] pair_idx;
    logic [2:0] single_idx;
    logic rise;
    logic [31:0] gap;
    logic reload_eff;
    logic [7:0] bank;
    bmsi_pkg::t_bank_map map;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_screen  <= 1'b0;
            r_revision_b   <= 1'b0;
            r_edge_min_gap <= bmsi_pkg::EDGE_GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmsi_pkg::CFG_FOUR_SCREEN:  r_four_screen  <= i_cfg_wdata[0];
                bmsi_pkg::CFG_REVISION_B:   r_revision_b   <= i_cfg_wdata[0];
                bmsi_pkg::CFG_EDGE_MIN_GAP: r_edge_min_gap <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd     <= i_s_axis_tuser;
            r_in_address <= i_s_axis_tdata[15:0];
            r_in_value   <= i_s_axis_tdata[23:16];
            r_in_cycle   <= i_s_axis_tdata[55:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command       <= '0;
            r_pic_banks     <= '0;
            r_prog_banks    <= '0;
            r_ram_enabled   <= 1'b0;
            r_ram_protected <= 1'b0;
            r_mirror        <= 1'b0;
            r_irq_latch     <= '0;
            r_irq_count     <= '0;
            r_irq_reload    <= 1'b0;
            r_irq_enable    <= 1'b0;
            r_irq_pending   <= 1'b0;
            r_prev_bit12    <= 1'b0;
            r_last_edge     <= '0;
        end else if (advance) begin
            r_command       <= n_command;
            r_pic_banks     <= n_pic_banks;
            r_prog_banks    <= n_prog_banks;
            r_ram_enabled   <= n_ram_enabled;
            r_ram_protected <= n_ram_protected;
            r_mirror        <= n_mirror;
            r_irq_latch     <= n_irq_latch;
            r_irq_count     <= n_irq_count;
            r_irq_reload    <= n_irq_reload;
            r_irq_enable    <= n_irq_enable;
            r_irq_pending   <= n_irq_pending;
            r_prev_bit12    <= n_prev_bit12;
            r_last_edge     <= n_last_edge;
        end
    end

    assign sel        = r_command[2:0];
    assign pair_idx   = {sel[1:0], 1'b0};
    assign single_idx = sel + 3'd2;
    assign rise       = r_in_address[12] && !r_prev_bit12;
    assign gap        = r_in_cycle - r_last_edge;

    always_comb begin
        n_command       = r_command;
        n_pic_banks     = r_pic_banks;
        n_prog_banks    = r_prog_banks;
        n_ram_enabled   = r_ram_enabled;
        n_ram_protected = r_ram_protected;
        n_mirror        = r_mirror;
        n_irq_latch     = r_irq_latch;
        n_irq_count     = r_irq_count;
        n_irq_reload    = r_irq_reload;
        n_irq_enable    = r_irq_enable;
        n_irq_pending   = r_irq_pending;
        n_prev_bit12    = r_prev_bit12;
        n_last_edge     = r_last_edge;
        reload_eff      = r_irq_reload;

        case (r_in_cmd)
            bmsi_pkg::CMD_REG_WRITE: begin
                if (r_in_address[15]) begin
                    case (r_in_address[14:13])
                        bmsi_pkg::GRP_BANK: begin
                            if (!r_in_address[0]) begin
                                n_command = r_in_value;
                            end else if (sel < 3'd2) begin
                                // first two picture selects load an even/odd pair
                                n_pic_banks[pair_idx]        = {r_in_value[7:1], 1'b0};
                                n_pic_banks[pair_idx + 3'd1] = {r_in_value[7:1], 1'b1};
                            end else if (sel < 3'd6) begin
                                n_pic_banks[single_idx] = r_in_value;
                            end else begin
                                n_prog_banks[sel[0]] = r_in_value[5:0];
                            end
                        end
                        bmsi_pkg::GRP_MIRROR: begin
                            if (!r_in_address[0]) begin
                                if (!r_four_screen) begin
                                    n_mirror = r_in_value[0];
                                end
                            end else begin
                                n_ram_enabled   = r_in_value[7];
                                n_ram_protected = r_in_value[6];
                            end
                        end
                        bmsi_pkg::GRP_LATCH: begin
                            if (!r_in_address[0]) begin
                                n_irq_latch = r_in_value;
                            end else begin
                                n_irq_count  = '0;
                                n_irq_reload = 1'b1;
                            end
                        end
                        default: begin
                            if (!r_in_address[0]) begin
                                n_irq_enable  = 1'b0;
                                n_irq_pending = 1'b0;
                            end else begin
                                n_irq_enable = 1'b1;
                            end
                        end
                    endcase
                end
            end
            bmsi_pkg::CMD_PIC_UPDATE: begin
                if (rise) begin
                    if (gap >= {24'd0, r_edge_min_gap}) begin
                        // counter clock: reload at zero, else count down
                        if (r_irq_count == 8'd0) begin
                            n_irq_count = r_irq_latch;
                        end else begin
                            n_irq_count = r_irq_count - 8'd1;
                            reload_eff  = 1'b1;
                        end
                        if (r_irq_enable && n_irq_count == 8'd0
                            && (r_revision_b || reload_eff)) begin
                            n_irq_pending = 1'b1;
                        end
                        n_irq_reload = 1'b0;
                    end
                    n_last_edge = r_in_cycle;
                end
                n_prev_bit12 = r_in_address[12];
            end
            default: ;
        endcase
    end

    always_comb begin
        map.swap_prg   = r_command[6];
        map.swap_pic   = r_command[7];
        map.pic_banks  = r_pic_banks;
        map.prog_banks = r_prog_banks;
    end

    bmsi_translate u_translate (
        .i_cmd     (r_in_cmd),
        .i_address (r_in_address),
        .i_map     (map),
        .o_bank    (bank)
    );

    always_comb begin
        n_out_data = {4'b0000,
                      n_mirror,
                      n_ram_enabled && !n_ram_protected && !r_four_screen,
                      n_ram_enabled && !r_four_screen,
                      n_irq_pending,
                      bank};
    end

endmodule

@@ dv/bank_mapper_scanline_irq_unit_tb.sv @@
`timescale 1ns / 100ps

module bank_mapper_scanline_irq_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 5;
    localparam int ITEMS_PER_PHASE = 265;
    localparam bit [PHASES-1:0] FOUR_SCREEN_SEQ = 5'b01010;
    localparam bit [PHASES-1:0] REVISION_B_SEQ  = 5'b00110;

    typedef struct packed {
        logic [bmsi_pkg::CMD_W-1:0]   kind;
        logic [bmsi_pkg::ADDR_W-1:0]  addr;
        logic [bmsi_pkg::VALUE_W-1:0] data;
        logic [bmsi_pkg::CYCLE_W-1:0] stamp;
    } t_bus_item;

    // bit order matches the output tdata from bit 11 down to bit 0
    typedef struct packed {
        logic                        mirror_h;
        logic                        ram_wr;
        logic                        ram_rd;
        logic                        irq;
        logic [bmsi_pkg::BANK_W-1:0] bank;
    } t_mapper_status;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [1:0]                      i_cfg_index = '0;
    logic [7:0]                      i_cfg_wdata = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [bmsi_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // address, value, ppu_cycle
    logic [bmsi_pkg::CMD_W-1:0]      i_s_axis_tuser = '0;   // cmd
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [bmsi_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;  // bank, irq, ram rd, ram wr, mirror

    bank_mapper_scanline_irq_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // mapper state mirrored by the predictor
    logic                       cfg_four_screen;
    logic                       cfg_rev_b;
    logic [7:0]                 cfg_min_gap;
    logic [7:0]                 bank_sel;
    logic [7:0]                 pic_page [8];
    logic [bmsi_pkg::PRG_W-1:0] prog_page [2];
    logic                       wram_en;
    logic                       wram_wp;
    logic                       mirror_h;
    logic [7:0]                 scan_reload_val;
    logic [7:0]                 scan_count;
    logic                       scan_reload_req;
    logic                       scan_irq_en;
    logic                       scan_irq;
    logic                       a12_last;
    logic [31:0]                a12_rise_cyc;

    t_bus_item      item_backlog [$];
    t_mapper_status status_due [$];
    t_bus_item      taken_item;
    t_mapper_status got_status;
    t_mapper_status want_status;

    logic [31:0] line_clock;
    bit          item_taken;
    bit          status_taken;
    bit          long_hold_done;
    int          hold_left;
    int          items_sent;
    int          results_seen;
    int          mismatches;
    int          idle_cycles;

    function automatic void reset_mapper_model();
        cfg_four_screen = 1'b0;
        cfg_rev_b       = 1'b0;
        cfg_min_gap     = bmsi_pkg::EDGE_GAP_RESET;
        bank_sel        = '0;
        for (int i = 0; i < 8; i++) pic_page[i] = '0;
        prog_page[0]    = '0;
        prog_page[1]    = '0;
        wram_en         = 1'b0;
        wram_wp         = 1'b0;
        mirror_h        = 1'b0;
        scan_reload_val = '0;
        scan_count      = '0;
        scan_reload_req = 1'b0;
        scan_irq_en     = 1'b0;
        scan_irq        = 1'b0;
        a12_last        = 1'b0;
        a12_rise_cyc    = '0;
    endfunction

    function automatic void scan_tick();
        if (scan_count == 8'd0) begin
            scan_count = scan_reload_val;
        end else begin
            scan_count      = scan_count - 8'd1;
            scan_reload_req = 1'b1;
        end
        if (scan_irq_en && scan_count == 8'd0 && (cfg_rev_b || scan_reload_req))
            scan_irq = 1'b1;
        scan_reload_req = 1'b0;
    endfunction

    function automatic void apply_reg_write(logic [15:0] addr, logic [7:0] data);
        logic [2:0] sel;
        sel = bank_sel[2:0];
        if (!addr[15]) return;
        case (addr[14:13])
            bmsi_pkg::GRP_BANK: begin
                if (!addr[0]) begin
                    bank_sel = data;
                end else if (sel < 3'd2) begin
                    // 2 KB picture banks: pair forced even/odd
                    pic_page[{sel[1:0], 1'b0}] = {data[7:1], 1'b0};
                    pic_page[{sel[1:0], 1'b1}] = {data[7:1], 1'b1};
                end else if (sel < 3'd6) begin
                    pic_page[3'(sel + 3'd2)] = data;
                end else begin
                    prog_page[sel[0]] = data[bmsi_pkg::PRG_W-1:0];
                end
            end
            bmsi_pkg::GRP_MIRROR: begin
                if (!addr[0]) begin
                    if (!cfg_four_screen) mirror_h = data[0];
                end else begin
                    wram_en = data[7];
                    wram_wp = data[6];
                end
            end
            bmsi_pkg::GRP_LATCH: begin
                if (!addr[0]) begin
                    scan_reload_val = data;
                end else begin
                    scan_count      = '0;
                    scan_reload_req = 1'b1;
                end
            end
            default: begin
                if (!addr[0]) begin
                    scan_irq_en = 1'b0;
                    scan_irq    = 1'b0;
                end else begin
                    scan_irq_en = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] cpu_slot_bank(logic [15:0] addr);
        logic [1:0] slot;
        if (!addr[15]) return '0;
        slot = addr[14:13];
        if (!slot[0] && bank_sel[6]) slot[1] = ~slot[1];
        case (slot)
            2'd0:    return 8'(prog_page[0]);
            2'd1:    return 8'(prog_page[1]);
            2'd2:    return bmsi_pkg::PRG_FIXED_SECOND;
            default: return bmsi_pkg::PRG_FIXED_LAST;
        endcase
    endfunction

    function automatic logic [7:0] pic_slot_bank(logic [15:0] addr);
        logic [2:0] slot;
        if (addr[15:13] != 3'd0) return '0;
        slot = addr[12:10];
        if (bank_sel[7]) slot[2] = ~slot[2];
        return pic_page[slot];
    endfunction

    function automatic t_mapper_status mapper_step(t_bus_item it);
        t_mapper_status st;
        logic [31:0]    since_rise;
        st.bank = '0;
        case (it.kind)
            bmsi_pkg::CMD_REG_WRITE: apply_reg_write(it.addr, it.data);
            bmsi_pkg::CMD_PIC_UPDATE: begin
                if (it.addr[12] && !a12_last) begin
                    since_rise = it.stamp - a12_rise_cyc;
                    if (since_rise >= 32'(cfg_min_gap)) scan_tick();
                    a12_rise_cyc = it.stamp;
                end
                a12_last = it.addr[12];
            end
            bmsi_pkg::CMD_CPU_XLATE: st.bank = cpu_slot_bank(it.addr);
            default:                 st.bank = pic_slot_bank(it.addr);
        endcase
        st.irq      = scan_irq;
        st.ram_rd   = wram_en && !cfg_four_screen;
        st.ram_wr   = wram_en && !wram_wp && !cfg_four_screen;
        st.mirror_h = mirror_h;
        return st;
    endfunction

    function automatic void push_item(logic [1:0] kind, logic [15:0] addr, logic [7:0] data,
                                      logic [31:0] stamp);
        t_bus_item it;
        it.kind  = kind;
        it.addr  = addr;
        it.data  = data;
        it.stamp = stamp;
        item_backlog.push_back(it);
    endfunction

    // returns the number of items queued
    function automatic int queue_random_items();
        logic [15:0] addr;
        logic [7:0]  data;
        logic [1:0]  grp;
        int          pick;
        addr = 16'($urandom);
        data = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 30) begin
            pick = $urandom_range(99);
            grp = (pick < 35) ? bmsi_pkg::GRP_BANK : (pick < 50) ? bmsi_pkg::GRP_MIRROR :
                  (pick < 72) ? bmsi_pkg::GRP_LATCH : bmsi_pkg::GRP_ENABLE;
            addr[15:13] = {($urandom_range(19) != 0), grp};
            // short latch values make the counter hit zero often
            if (grp == bmsi_pkg::GRP_LATCH && !addr[0] && $urandom_range(1) == 1)
                data = 8'($urandom_range(6));
            if (grp == bmsi_pkg::GRP_ENABLE) addr[0] = ($urandom_range(9) < 7);
            push_item(bmsi_pkg::CMD_REG_WRITE, addr, data, $urandom);
            return 1;
        end
        if (pick < 60) begin
            // one scanline: bit 12 low, then a rise with an advancing stamp
            addr[12] = 1'b0;
            push_item(bmsi_pkg::CMD_PIC_UPDATE, addr, data, $urandom);
            pick = $urandom_range(99);
            line_clock += (pick < 70) ? 32'($urandom_range(400, 256)) :
                          (pick < 90) ? 32'($urandom_range(40)) : $urandom;
            push_item(bmsi_pkg::CMD_PIC_UPDATE, 16'($urandom) | 16'h1000, 8'($urandom),
                      line_clock);
            return 2;
        end
        if (pick < 78) begin
            if ($urandom_range(99) < 85) addr[15] = 1'b1;
            push_item(bmsi_pkg::CMD_CPU_XLATE, addr, data, $urandom);
            return 1;
        end
        if (pick < 95) begin
            if ($urandom_range(99) < 85) addr[15:13] = 3'd0;
            push_item(bmsi_pkg::CMD_PIC_XLATE, addr, data, $urandom);
            return 1;
        end
        push_item(2'($urandom), addr, data, $urandom);
        return 1;
    endfunction

    task automatic report_mismatch(string field, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [7:0] wdata);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= wdata;
        @(posedge i_clk);
        case (index)
            bmsi_pkg::CFG_FOUR_SCREEN: cfg_four_screen = wdata[0];
            bmsi_pkg::CFG_REVISION_B:  cfg_rev_b       = wdata[0];
            default:                   cfg_min_gap     = wdata;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (item_backlog.size() != 0 || status_due.size() != 0) @(negedge i_clk);
        // two-stage pipeline, a little margin
        repeat (4) @(negedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || item_taken) begin
            if (item_backlog.size() != 0 &&
                ((items_sent >= 700 && items_sent < 850) || $urandom_range(99) >= 21)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {item_backlog[0].stamp, item_backlog[0].data,
                                    item_backlog[0].addr};
                i_s_axis_tuser  <= item_backlog[0].kind;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off so the block backs up into its input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 500) begin
            long_hold_done = 1'b1;
            hold_left = 150;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (results_seen >= 700 && results_seen < 850) ||
                               $urandom_range(99) >= 21;
        end
    end

    // acceptance, prediction, checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            item_taken   = i_s_axis_tvalid && o_s_axis_tready;
            status_taken = o_m_axis_tvalid && i_m_axis_tready;
            if (item_taken) begin
                taken_item = item_backlog.pop_front();
                status_due.push_back(mapper_step(taken_item));
                items_sent++;
            end
            if (status_taken) begin
                results_seen++;
                got_status = t_mapper_status'(o_m_axis_tdata[11:0]);
                if (status_due.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, int'(got_status));
                end else begin
                    want_status = status_due.pop_front();
                    if (got_status.bank !== want_status.bank)
                        report_mismatch("bank", want_status.bank, got_status.bank);
                    if (got_status.irq !== want_status.irq)
                        report_mismatch("irq_line", want_status.irq, got_status.irq);
                    if (got_status.ram_rd !== want_status.ram_rd)
                        report_mismatch("ram_read_ok", want_status.ram_rd, got_status.ram_rd);
                    if (got_status.ram_wr !== want_status.ram_wr)
                        report_mismatch("ram_write_ok", want_status.ram_wr, got_status.ram_wr);
                    if (got_status.mirror_h !== want_status.mirror_h)
                        report_mismatch("horiz_mirror", want_status.mirror_h,
                                        got_status.mirror_h);
                end
            end
            if (item_taken || status_taken) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int queued;
        reset_mapper_model();
        line_clock = $urandom;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                cfg_write(bmsi_pkg::CFG_FOUR_SCREEN, 8'(FOUR_SCREEN_SEQ[p]));
                cfg_write(bmsi_pkg::CFG_REVISION_B, 8'(REVISION_B_SEQ[p]));
                case (p)
                    1:       cfg_write(bmsi_pkg::CFG_EDGE_MIN_GAP, 8'd0);
                    2:       cfg_write(bmsi_pkg::CFG_EDGE_MIN_GAP, 8'd255);
                    3:       cfg_write(bmsi_pkg::CFG_EDGE_MIN_GAP, 8'd1);
                    default: cfg_write(bmsi_pkg::CFG_EDGE_MIN_GAP, 8'($urandom_range(254, 2)));
                endcase
            end else begin
                // below program space
                push_item(bmsi_pkg::CMD_CPU_XLATE,  16'h0000, 8'h00, 32'h0);
                // outside pattern space
                push_item(bmsi_pkg::CMD_PIC_XLATE,  16'hffff, 8'hff, 32'hffffffff);
                // work ram, no effect
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'h7fff, 8'hff, 32'h0);
                // both swaps, select 6
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'h8000, 8'hc6, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'h8001, 8'hff, 32'h0);
                push_item(bmsi_pkg::CMD_CPU_XLATE,  16'h8000, 8'h00, 32'h0);
                push_item(bmsi_pkg::CMD_CPU_XLATE,  16'hc000, 8'h00, 32'h0);
                push_item(bmsi_pkg::CMD_PIC_XLATE,  16'h0000, 8'h00, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'h8000, 8'h00, 32'h0);
                // forced even/odd pair
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'h8001, 8'hff, 32'h0);
                push_item(bmsi_pkg::CMD_PIC_XLATE,  16'h07ff, 8'h00, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'ha000, 8'h01, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'ha001, 8'hc0, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'ha001, 8'h80, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'hc000, 8'h01, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'hc001, 8'h00, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'he001, 8'h00, 32'h0);
                push_item(bmsi_pkg::CMD_PIC_UPDATE, 16'h1000, 8'h00, 32'h100);
                push_item(bmsi_pkg::CMD_PIC_UPDATE, 16'h0000, 8'h00, 32'h104);
                // rise too close
                push_item(bmsi_pkg::CMD_PIC_UPDATE, 16'h1000, 8'h00, 32'h108);
                push_item(bmsi_pkg::CMD_PIC_UPDATE, 16'h0000, 8'h00, 32'h10c);
                // counts down to zero
                push_item(bmsi_pkg::CMD_PIC_UPDATE, 16'h1000, 8'h00, 32'h200);
                push_item(bmsi_pkg::CMD_CPU_XLATE,  16'hffff, 8'hff, 32'h0);
                // disable clears irq
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'he000, 8'h00, 32'h0);
                push_item(bmsi_pkg::CMD_REG_WRITE,  16'he001, 8'h00, 32'h0);
            end
            queued = 0;
            while (queued < ITEMS_PER_PHASE) queued += queue_random_items();
        end

        wait_drained();
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
